FILE: design/qph_pkg.sv
// qph_pkg: shared types and constants of the quadratic-probe hash table
// request and response beats, controller command and datapath status structs
// no dependencies

package qph_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 31;
  localparam int PAY_W     = 32;
  localparam int STAT_W    = 3;
  localparam int SLOT_W    = 4;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [PAY_W-1:0]  found_payload;
  } rsp_t;

  typedef struct packed {
    logic              clr_wr;
    logic              capture;
    logic              hash;
    logic              home;
    logic              advance;
    logic              ins_wr;
    logic              emit;
    logic              emit_slot;
    logic              emit_pay;
    logic [STAT_W-1:0] emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit_valid;
    logic key_match;
    logic probe_last;
    logic search;
  } dp_status_t;

endpackage

FILE: design/qph_ctrl.sv
// qph_ctrl: controller state machine of the hash table
// sequences clearing pass, hash, home read, probe loop and result; uses qph_pkg

module qph_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  qph_pkg::dp_status_t sts_i,
  output qph_pkg::dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_HOME  = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = ST_HOME;
      end
      ST_HOME: begin
        cmd_o.home = 1'b1;
        state_d    = ST_PROBE;
      end
      ST_PROBE: begin
        priority if (!sts_i.hit_valid) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
          if (sts_i.search) begin
            cmd_o.emit_status = qph_pkg::ST_NOT_FOUND;
          end else begin
            cmd_o.ins_wr      = 1'b1;
            cmd_o.emit_slot   = 1'b1;
            cmd_o.emit_status = qph_pkg::ST_INSERTED;
          end
        end else if (sts_i.key_match) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_slot   = 1'b1;
          cmd_o.emit_pay    = 1'b1;
          cmd_o.emit_status = sts_i.search ? qph_pkg::ST_FOUND : qph_pkg::ST_DUPLICATE;
          state_d           = ST_IDLE;
        end else if (sts_i.probe_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = sts_i.search ? qph_pkg::ST_NOT_FOUND : qph_pkg::ST_FULL;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: design/qph_dp.sv
// qph_dp: datapath of the hash table
// slot memory, home-slot reduction, probe index stepping, result register; uses qph_pkg

module qph_dp #(
  parameter int SLOTS = qph_pkg::SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qph_pkg::req_t       req_i,
  input  qph_pkg::dp_cmd_t    cmd_i,
  output qph_pkg::dp_status_t sts_o,
  output logic                valid_o,
  output qph_pkg::rsp_t       rsp_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int RW = IW + 1;
  localparam int KW = qph_pkg::KEY_W;
  localparam int PW = qph_pkg::PAY_W;
  localparam int SW = qph_pkg::SLOT_W;
  localparam logic [RW-1:0] SLOTS_R  = RW'(SLOTS);
  localparam logic [63:0]   RECIP64  = (64'd1 << 32) / 64'(SLOTS);
  localparam logic [31:0]   RECIP    = RECIP64[31:0];
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef struct packed {
    logic          used;
    logic [KW-1:0] key;
    logic [PW-1:0] payload;
  } entry_t;

  entry_t        mem [SLOTS];
  entry_t        rd_q;
  logic          op_q;
  logic [KW-1:0] key_q;
  logic [PW-1:0] pay_q;
  logic [KW-1:0] quo_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] step_q;
  logic [IW-1:0] att_q;
  logic [IW-1:0] clr_cnt_q;
  logic          valid_q;
  qph_pkg::rsp_t rsp_q;

  logic [KW+32-1:0] prod;
  logic [RW-1:0]    rem_raw, rem_fix, idx_sum, idx_wrap, step_sum, step_wrap;
  logic [IW-1:0]    home_idx, next_idx, rd_addr, wr_addr;
  logic             wr_en;
  entry_t           wr_data;
  logic [IW+SW-1:0] slot_ext;

  // home slot: quotient by reciprocal, then remainder from the low bits
  assign prod     = (KW+32)'(key_q) * (KW+32)'(RECIP);
  assign rem_raw  = key_q[RW-1:0] - RW'(quo_q[RW-1:0] * SLOTS_R);
  assign rem_fix  = (rem_raw >= SLOTS_R) ? (rem_raw - SLOTS_R) : rem_raw;
  assign home_idx = rem_fix[IW-1:0];

  // quadratic path: the gap to the next probe grows by two each time
  assign idx_sum   = {1'b0, idx_q} + {1'b0, step_q};
  assign idx_wrap  = (idx_sum >= SLOTS_R) ? (idx_sum - SLOTS_R) : idx_sum;
  assign next_idx  = idx_wrap[IW-1:0];
  assign step_sum  = {1'b0, step_q} + RW'(2);
  assign step_wrap = (step_sum >= SLOTS_R) ? (step_sum - SLOTS_R) : step_sum;

  assign rd_addr = cmd_i.home ? home_idx : next_idx;
  assign wr_en   = cmd_i.clr_wr | cmd_i.ins_wr;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : idx_q;
  assign wr_data = cmd_i.clr_wr ? entry_t'('0) : entry_t'({1'b1, key_q, pay_q});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key;
      pay_q <= req_i.payload;
    end
    if (cmd_i.hash) begin
      quo_q <= prod[KW+32-1:32];
    end
    if (cmd_i.home) begin
      idx_q  <= home_idx;
      step_q <= IW'(1);
      att_q  <= '0;
    end else if (cmd_i.advance) begin
      idx_q  <= next_idx;
      step_q <= step_wrap[IW-1:0];
      att_q  <= att_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + IW'(1);
      end
    end
  end

  assign slot_ext = {{SW{1'b0}}, idx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.status        <= cmd_i.emit_status;
      rsp_q.slot          <= cmd_i.emit_slot ? slot_ext[SW-1:0] : '0;
      rsp_q.found_payload <= cmd_i.emit_pay ? rd_q.payload : '0;
    end
  end

  assign sts_o.clr_last   = (clr_cnt_q == LAST_IDX);
  assign sts_o.hit_valid  = rd_q.used;
  assign sts_o.key_match  = (rd_q.key == key_q);
  assign sts_o.probe_last = (att_q == LAST_IDX);
  assign sts_o.search     = (op_q == qph_pkg::OP_SEARCH);

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: design/quadratic_probe_hash_table_top.sv
// quadratic_probe_hash_table_top: top level of the quadratic-probe hash table
// joins qph_ctrl and qph_dp; uses qph_pkg

// An operation beat (insert or search of a 31-bit key) is taken at a rising
// edge where start is high and busy is low. The one result beat appears on
// rsp_o with valid_o high for exactly one cycle and is not held: the
// receiver must take it then. An operation runs through the hash and home
// read states and then probes between 1 and SLOTS slots; the probe loop
// reads one slot of the slot memory per cycle, and busy stays high, so no
// new beat is taken, until the result is given. After reset a clearing
// pass empties every slot of the slot memory, with busy high, before the
// first operation is taken.

module quadratic_probe_hash_table_top #(
  parameter int SLOTS = qph_pkg::SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  qph_pkg::req_t req_i,
  output logic          valid_o,
  output qph_pkg::rsp_t rsp_o
);

  // command and status between controller and datapath
  qph_pkg::dp_cmd_t    cmd;
  qph_pkg::dp_status_t sts;

  // state machine: clearing pass, hash, home read, probe loop
  qph_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // slot memory, index arithmetic and the result register
  qph_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

FILE: design/qph_checker.sv
// qph_checker: port-level assertions for the hash table top level
// bound to quadratic_probe_hash_table_top; uses qph_pkg

module qph_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          valid_o,
  input qph_pkg::rsp_t rsp_o
);

  // a result beat only shows once the block is free again
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result beat while busy");

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // one result per operation, never two in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // payload is only reported for a matched entry
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (rsp_o.status == qph_pkg::ST_INSERTED ||
                 rsp_o.status == qph_pkg::ST_FULL ||
                 rsp_o.status == qph_pkg::ST_NOT_FOUND)) |-> (rsp_o.found_payload == '0))
    else $error("payload on a result without match");

  // no slot on a miss
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (rsp_o.status == qph_pkg::ST_FULL ||
                 rsp_o.status == qph_pkg::ST_NOT_FOUND)) |-> (rsp_o.slot == '0))
    else $error("slot on a miss");

endmodule

bind quadratic_probe_hash_table_top qph_checker u_qph_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);
